// ===== rtl/ipcl_pkg.sv =====
package ipcl_pkg;

  localparam int MAX_PACKET_BYTES = 512;
  localparam int OFF_W = $clog2(MAX_PACKET_BYTES + 1);

  localparam logic [7:0] TYPE_TIME_EXCEEDED    = 8'd11;
  localparam logic [7:0] CODE_TTL_EXPIRED      = 8'd0;
  localparam logic [7:0] TYPE_UNREACHABLE      = 8'd3;
  localparam logic [7:0] CODE_PORT_UNREACHABLE = 8'd3;

  localparam logic [5:0] ICMP_HDR_BYTES = 6'd8;
  localparam logic [15:0] BASE_PORT_RESET = 16'd33434;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_PORT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_SEQ = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_OTHER   = 2'd0,
    VERDICT_HOP     = 2'd1,
    VERDICT_REACHED = 2'd2
  } verdict_e;

  // Fields captured from one packet, handed over on its final byte.
  typedef struct packed {
    logic        valid;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [15:0] quoted_port;
    logic        port_complete;
    logic [31:0] source_address;
  } pkt_summary_t;

  // Header length field (low nibble) in bytes.
  function automatic logic [5:0] hdr_len(input logic [7:0] b);
    return {b[3:0], 2'b00};
  endfunction

endpackage

// ===== rtl/ipcl_ifs.sv =====
interface ipcl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface ipcl_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic        truncated;
  logic [31:0] hop_address;

  modport source (output valid, output verdict, output truncated, output hop_address,
                  input ready);
  modport sink   (input valid, input verdict, input truncated, input hop_address,
                  output ready);
endinterface

// ===== rtl/ipcl_parser.sv =====
module ipcl_parser
  import ipcl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [7:0]   in_byte_i,
  input  logic         in_last_i,
  input  logic         res_take_i,
  output pkt_summary_t summary_o
);

  logic             in_valid_q;
  logic [7:0]       byte_q;
  logic             last_q;
  logic             advance;

  logic [OFF_W-1:0] off_q, off_d;
  logic [5:0]       ol_q, ol_d;
  logic [5:0]       il_q, il_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       code_q, code_d;
  logic [15:0]      port_q, port_d;
  logic             done_q, done_d;
  logic [31:0]      src_q, src_d;

  logic [5:0]       ol_u, il_u;
  logic [7:0]       type_u, code_u;
  logic [15:0]      port_u;
  logic             done_u;
  logic [31:0]      src_u;
  logic [OFF_W-1:0] ol_at, inner_at, port_at;
  logic             in_range;

  // Hold a final byte while the result register is still full.
  assign advance    = in_valid_q && (!last_q || res_take_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  always_comb begin
    in_range = off_q < OFF_W'(MAX_PACKET_BYTES);
    ol_u   = ol_q;
    il_u   = il_q;
    type_u = type_q;
    code_u = code_q;
    port_u = port_q;
    done_u = done_q;
    src_u  = src_q;

    // Lengths take effect on the byte that carries them.
    if (off_q == '0) begin
      ol_u = hdr_len(byte_q);
    end
    ol_at    = OFF_W'(ol_u);
    inner_at = OFF_W'({1'b0, ol_u} + {1'b0, ICMP_HDR_BYTES});
    if (off_q == inner_at) begin
      il_u = hdr_len(byte_q);
    end
    port_at = inner_at + OFF_W'(il_u) + OFF_W'(2);

    unique case (off_q)
      OFF_W'(12): src_u[31:24] = byte_q;
      OFF_W'(13): src_u[23:16] = byte_q;
      OFF_W'(14): src_u[15:8]  = byte_q;
      OFF_W'(15): src_u[7:0]   = byte_q;
      default: ;
    endcase

    if (off_q == ol_at) begin
      type_u = byte_q;
    end
    if (off_q == ol_at + OFF_W'(1)) begin
      code_u = byte_q;
    end
    if (off_q == port_at) begin
      port_u[15:8] = byte_q;
    end
    if (off_q == port_at + OFF_W'(1)) begin
      port_u[7:0] = byte_q;
      done_u      = 1'b1;
    end

    // Drop bytes beyond the buffer size.
    if (!in_range) begin
      ol_u   = ol_q;
      il_u   = il_q;
      type_u = type_q;
      code_u = code_q;
      port_u = port_q;
      done_u = done_q;
      src_u  = src_q;
    end

    summary_o.valid          = advance && last_q;
    summary_o.icmp_type      = type_u;
    summary_o.icmp_code      = code_u;
    summary_o.quoted_port    = port_u;
    summary_o.port_complete  = done_u;
    summary_o.source_address = src_u;

    if (last_q) begin
      off_d  = '0;
      ol_d   = '0;
      il_d   = '0;
      type_d = '0;
      code_d = '0;
      port_d = '0;
      done_d = 1'b0;
      src_d  = '0;
    end else begin
      off_d  = in_range ? off_q + OFF_W'(1) : off_q;
      ol_d   = ol_u;
      il_d   = il_u;
      type_d = type_u;
      code_d = code_u;
      port_d = port_u;
      done_d = done_u;
      src_d  = src_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      ol_q   <= '0;
      il_q   <= '0;
      type_q <= '0;
      code_q <= '0;
      port_q <= '0;
      done_q <= 1'b0;
      src_q  <= '0;
    end else if (advance) begin
      off_q  <= off_d;
      ol_q   <= ol_d;
      il_q   <= il_d;
      type_q <= type_d;
      code_q <= code_d;
      port_q <= port_d;
      done_q <= done_d;
      src_q  <= src_d;
    end
  end

endmodule

// ===== rtl/ipcl_verdict.sv =====
module ipcl_verdict
  import ipcl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  pkt_summary_t          summary_i,
  output logic                  res_take_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            verdict_o,
  output logic                  truncated_o,
  output logic [31:0]           hop_address_o
);

  logic [15:0] base_port_q;
  logic [15:0] probe_seq_q;
  logic [15:0] expect_sum;
  logic [15:0] expect_port;
  verdict_e    verdict_d;
  logic        out_valid_q;
  verdict_e    verdict_q;
  logic        truncated_q;
  logic [31:0] hop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_port_q <= BASE_PORT_RESET;
      probe_seq_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BASE_PORT: base_port_q <= cfg_data_i;
        REG_PROBE_SEQ: probe_seq_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Port zero is never used by a probe: map it to one.
  assign expect_sum  = base_port_q + probe_seq_q;
  assign expect_port = (expect_sum == '0) ? 16'd1 : expect_sum;

  always_comb begin
    verdict_d = VERDICT_OTHER;
    if (summary_i.port_complete && summary_i.quoted_port == expect_port) begin
      priority if (summary_i.icmp_type == TYPE_TIME_EXCEEDED &&
                   summary_i.icmp_code == CODE_TTL_EXPIRED) begin
        verdict_d = VERDICT_HOP;
      end else if (summary_i.icmp_type == TYPE_UNREACHABLE &&
                   summary_i.icmp_code == CODE_PORT_UNREACHABLE) begin
        verdict_d = VERDICT_REACHED;
      end else begin
        verdict_d = VERDICT_OTHER;
      end
    end
  end

  assign res_take_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (summary_i.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (summary_i.valid) begin
      verdict_q   <= verdict_d;
      truncated_q <= !summary_i.port_complete;
      hop_q       <= summary_i.source_address;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign verdict_o     = verdict_q;
  assign truncated_o   = truncated_q;
  assign hop_address_o = hop_q;

endmodule

// ===== rtl/icmp_probe_reply_classifier_core.sv =====
// The input register captures each accepted byte, which is parsed from there;
// the verdict word of a packet is registered from the summary of its final byte.
// Throughput: one byte per cycle, set by the input register and single-pass
// field capture; a final byte waits only while the result word is stalled.
// Reset: asynchronous, active low; clears packet state and handshakes, loads
// base_port with 33434 and probe_seq with 0.
module icmp_probe_reply_classifier_core
  import ipcl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ipcl_byte_if.sink             pkt_i,
  ipcl_result_if.source         res_o
);

  pkt_summary_t summary;
  logic         res_take;

  ipcl_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pkt_i.valid),
    .in_ready_o (pkt_i.ready),
    .in_byte_i  (pkt_i.packet_byte),
    .in_last_i  (pkt_i.last_byte),
    .res_take_i (res_take),
    .summary_o  (summary)
  );

  ipcl_verdict u_verdict (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .summary_i     (summary),
    .res_take_o    (res_take),
    .out_valid_o   (res_o.valid),
    .out_ready_i   (res_o.ready),
    .verdict_o     (res_o.verdict),
    .truncated_o   (res_o.truncated),
    .hop_address_o (res_o.hop_address)
  );

endmodule

// ===== rtl/ipcl_checker.sv =====
module ipcl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  verdict_i,
  input logic        truncated_i,
  input logic [31:0] hop_address_i
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(verdict_i) && $stable(truncated_i) && $stable(hop_address_i))
    else $error("result word changed while stalled");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> verdict_i != 2'd3)
    else $error("verdict code out of range");

  a_trunc_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && truncated_i |-> verdict_i == 2'd0)
    else $error("truncated packet classified");

endmodule

bind icmp_probe_reply_classifier_core ipcl_checker u_ipcl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .verdict_i     (res_o.verdict),
  .truncated_i   (res_o.truncated),
  .hop_address_i (res_o.hop_address)
);
